@@ hw/rtl/lcdseq_pkg.sv @@
// Package for the character LCD 4-bit write sequencer.
// Holds the beat structs, the control word format and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps

package lcdseq_pkg;

    // Request and event beats
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] value;
        logic       row;
        logic [3:0] col;
    } t_req;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_sel;
        logic        strobe_res;
        logic [15:0] wait_us;
        logic        last;
    } t_evt;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_CMD  = 2'd1,
        ACT_POS  = 2'd2,
        ACT_CHAR = 2'd3
    } t_action;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_SET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_CTRL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY     = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_POWER_UP  = 16'd40000;
    localparam logic [15:0] RST_SETTLE    = 16'd100;
    localparam logic [7:0]  RST_FUNC_SET  = 8'h28;
    localparam logic [7:0]  RST_DISP_CTRL = 8'h0F;
    localparam logic [7:0]  RST_ENTRY     = 8'h06;

    // Fixed bytes and waits
    localparam logic [7:0]  WAKE_BYTE     = 8'h33;
    localparam logic [7:0]  FOUR_BIT_BYTE = 8'h22;
    localparam logic [7:0]  SHIFT_CMD     = 8'h10;
    localparam logic [3:0]  DDRAM_BASE    = 4'h8;
    localparam logic [15:0] WAKE_SETTLE   = 16'd5000;
    localparam logic [15:0] WAKE_GAP      = 16'd160;

    // Control word
    typedef enum logic [3:0] {
        BS_ZERO,
        BS_WAKE,
        BS_FOUR,
        BS_FUNC,
        BS_SHIFT,
        BS_DISP,
        BS_ENTRY,
        BS_VALUE,
        BS_POS
    } t_byte_sel;

    typedef enum logic [2:0] {
        WS_ZERO,
        WS_POWER,
        WS_WAKE,
        WS_GAP,
        WS_SETTLE
    } t_wait_sel;

    typedef struct packed {
        t_byte_sel byte_sel;
        logic      hi;
        logic      rs;
        logic      strobe;
        t_wait_sel wait_sel;
        logic      last;
    } t_cw;

    // Sequencer to datapath control
    typedef struct packed {
        logic load;
        logic emit;
        t_cw  cw;
    } t_uctl;

    localparam int STEP_W = 5;

    // Program entry points
    localparam logic [STEP_W-1:0] EP_INIT = 5'd0;
    localparam logic [STEP_W-1:0] EP_CMD  = 5'd14;
    localparam logic [STEP_W-1:0] EP_POS  = 5'd16;
    localparam logic [STEP_W-1:0] EP_CHAR = 5'd18;

    function automatic logic [STEP_W-1:0] entry_step(input logic [1:0] action);
        logic [STEP_W-1:0] s;
        unique case (t_action'(action))
            ACT_INIT: s = EP_INIT;
            ACT_CMD:  s = EP_CMD;
            ACT_POS:  s = EP_POS;
            ACT_CHAR: s = EP_CHAR;
            default:  s = EP_INIT;
        endcase
        return s;
    endfunction

    function automatic t_cw mk(t_byte_sel b, logic hi, logic rs, logic stb,
                               t_wait_sel w, logic lst);
        t_cw c;
        c.byte_sel = b;
        c.hi       = hi;
        c.rs       = rs;
        c.strobe   = stb;
        c.wait_sel = w;
        c.last     = lst;
        return c;
    endfunction

    // Microcode ROM: one bus event per step
    function automatic t_cw ucode(input logic [STEP_W-1:0] step);
        t_cw c;
        unique case (step)
            // initialize
            5'd0:    c = mk(BS_ZERO,  1'b0, 1'b0, 1'b0, WS_POWER,  1'b0);
            5'd1:    c = mk(BS_WAKE,  1'b0, 1'b0, 1'b0, WS_WAKE,   1'b0);
            5'd2:    c = mk(BS_WAKE,  1'b0, 1'b0, 1'b1, WS_GAP,    1'b0);
            5'd3:    c = mk(BS_WAKE,  1'b0, 1'b0, 1'b1, WS_GAP,    1'b0);
            5'd4:    c = mk(BS_WAKE,  1'b0, 1'b0, 1'b1, WS_GAP,    1'b0);
            5'd5:    c = mk(BS_FOUR,  1'b0, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd6:    c = mk(BS_FUNC,  1'b1, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd7:    c = mk(BS_FUNC,  1'b0, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd8:    c = mk(BS_SHIFT, 1'b1, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd9:    c = mk(BS_SHIFT, 1'b0, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd10:   c = mk(BS_DISP,  1'b1, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd11:   c = mk(BS_DISP,  1'b0, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd12:   c = mk(BS_ENTRY, 1'b1, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd13:   c = mk(BS_ENTRY, 1'b0, 1'b0, 1'b1, WS_ZERO,   1'b1);
            // command byte
            5'd14:   c = mk(BS_VALUE, 1'b1, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd15:   c = mk(BS_VALUE, 1'b0, 1'b0, 1'b1, WS_ZERO,   1'b1);
            // set position
            5'd16:   c = mk(BS_POS,   1'b1, 1'b0, 1'b1, WS_ZERO,   1'b0);
            5'd17:   c = mk(BS_POS,   1'b0, 1'b0, 1'b1, WS_SETTLE, 1'b1);
            // print character
            5'd18:   c = mk(BS_VALUE, 1'b1, 1'b1, 1'b1, WS_ZERO,   1'b0);
            5'd19:   c = mk(BS_VALUE, 1'b0, 1'b1, 1'b1, WS_SETTLE, 1'b1);
            default: c = mk(BS_ZERO,  1'b0, 1'b0, 1'b0, WS_ZERO,   1'b1);
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/char_lcd_nibble_write_sequencer_top.sv @@
// Character LCD 4-bit write sequencer, top level.
// An accepted request loads the step counter; its first event beat is then
// registered in the output register. One event beat per cycle while the
// output takes beats; initialize has 14 steps, the other requests 2.
// Reset (synchronous, active low) idles the sequencer and restores config.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  lcdseq_pkg::t_req                     i_in_data,
    // event channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output lcdseq_pkg::t_evt                     o_out_data,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [lcdseq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lcdseq_pkg::*;

    t_uctl ctl;
    logic  out_free;

    // Sequencer walks the microcode program; a new request is taken in the
    // same cycle the final event of the previous run is issued.
    lcdseq_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_ctl      (ctl)
    );

    // Datapath builds each event from the control word and drives the
    // output register; advance only when that register can take a beat.
    lcdseq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_data),
        .i_ctl       (ctl),
        .i_out_ready (i_out_ready),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hw/rtl/lcdseq_useq.sv @@
// Microsequencer: step counter, entry dispatch and control word fetch.
// Depends on lcdseq_pkg.
`timescale 1ns / 1ps

module lcdseq_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_action,
    input  logic                 i_out_free,
    output logic                 o_in_ready,
    output lcdseq_pkg::t_uctl    o_ctl
);
    import lcdseq_pkg::*;

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    t_cw               cw;
    logic              emit, done, accept;

    assign cw     = ucode(r_step);
    assign emit   = r_busy & i_out_free;
    assign done   = emit & cw.last;
    assign o_in_ready = ~r_busy | done;
    assign accept = i_in_valid & o_in_ready;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (accept) begin
            n_busy = 1'b1;
            n_step = entry_step(i_action);
        end else if (done) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_ctl.load = accept;
    assign o_ctl.emit = emit;
    assign o_ctl.cw   = cw;

endmodule

@@ hw/rtl/lcdseq_dp.sv @@
// Datapath: configuration registers, request latch, nibble and wait
// selection, output event register. Depends on lcdseq_pkg.
`timescale 1ns / 1ps

module lcdseq_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lcdseq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  lcdseq_pkg::t_req                     i_req,
    input  lcdseq_pkg::t_uctl                    i_ctl,
    input  logic                                 i_out_ready,
    output logic                                 o_out_free,
    output logic                                 o_out_valid,
    output lcdseq_pkg::t_evt                     o_out_data
);
    import lcdseq_pkg::*;

    logic [15:0] r_power_up, r_settle;
    logic [7:0]  r_func, r_disp, r_entry;
    t_req        r_req;
    logic        r_valid;
    t_evt        r_evt, n_evt;
    logic [7:0]  sel_byte;
    logic [15:0] sel_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_up <= RST_POWER_UP;
            r_settle   <= RST_SETTLE;
            r_func     <= RST_FUNC_SET;
            r_disp     <= RST_DISP_CTRL;
            r_entry    <= RST_ENTRY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POWER_UP:  r_power_up <= i_cfg_data;
                CFG_SETTLE:    r_settle   <= i_cfg_data;
                CFG_FUNC_SET:  r_func     <= i_cfg_data[7:0];
                CFG_DISP_CTRL: r_disp     <= i_cfg_data[7:0];
                CFG_ENTRY:     r_entry    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted request for the length of its run
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
        end
    end

    always_comb begin
        unique case (i_ctl.cw.byte_sel)
            BS_ZERO:  sel_byte = 8'h00;
            BS_WAKE:  sel_byte = WAKE_BYTE;
            BS_FOUR:  sel_byte = FOUR_BIT_BYTE;
            BS_FUNC:  sel_byte = r_func;
            BS_SHIFT: sel_byte = SHIFT_CMD;
            BS_DISP:  sel_byte = r_disp;
            BS_ENTRY: sel_byte = r_entry;
            BS_VALUE: sel_byte = r_req.value;
            BS_POS:   sel_byte = {DDRAM_BASE | {1'b0, r_req.row, 2'b00}, r_req.col};
            default:  sel_byte = 8'h00;
        endcase
        unique case (i_ctl.cw.wait_sel)
            WS_ZERO:   sel_wait = 16'd0;
            WS_POWER:  sel_wait = r_power_up;
            WS_WAKE:   sel_wait = WAKE_SETTLE;
            WS_GAP:    sel_wait = WAKE_GAP;
            WS_SETTLE: sel_wait = r_settle;
            default:   sel_wait = 16'd0;
        endcase
        n_evt.nibble     = i_ctl.cw.hi ? sel_byte[7:4] : sel_byte[3:0];
        n_evt.reg_sel    = i_ctl.cw.rs;
        n_evt.strobe_res = i_ctl.cw.strobe;
        n_evt.wait_us    = sel_wait;
        n_evt.last       = i_ctl.cw.last;
    end

    assign o_out_free = ~r_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_evt <= n_evt;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_evt;

endmodule
